// ===== src/vtp_pkg.sv =====
// Package for the virtual timer pool: item, command and status structs, action and
// result codes, register indexes, reset values and controller state encoding.
// No dependencies.
`default_nettype none

package vtp_pkg;

   // Default pool size and the width of the slot field, which can address up to 16 slots.
   localparam int NUM_SLOTS_DEF = 6;
   localparam int SLOT_FIELD_W  = 4;

   // Input action codes.
   localparam logic [1:0] ACT_START = 2'd0;
   localparam logic [1:0] ACT_STOP  = 2'd1;
   localparam logic [1:0] ACT_TICK  = 2'd2;

   // Result kind codes.
   localparam logic [1:0] KIND_START  = 2'd0;
   localparam logic [1:0] KIND_STOP   = 2'd1;
   localparam logic [1:0] KIND_EXPIRY = 2'd2;

   // Configuration register indexes.
   localparam logic CSR_BASE_RUNNING = 1'b0;
   localparam logic CSR_TICK_STEP    = 1'b1;

   // Configuration reset values.
   localparam logic       BASE_RUNNING_RST = 1'b1;
   localparam logic [9:0] TICK_STEP_RST    = 10'd10;

   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] period_ms;
      logic        periodic;
      logic [3:0]  slot;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic        ok;
      logic [3:0]  slot_id;
      logic [15:0] period_out;
      logic        last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SCAN  = 3'b010,
      ST_FLUSH = 3'b100
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start_op;
      logic stop_op;
      logic scan_step;
      logic flush;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_last;
      logic pend_valid;
   } status_type;

endpackage

`default_nettype wire

// ===== src/vtp_datapath.sv =====
// Datapath of the virtual timer pool: slot store, tick scan, pending expiry
// holding register, result register and configuration registers.
// Depends on vtp_pkg.
`default_nettype none

module vtp_datapath #(
   parameter int NUM_SLOTS = vtp_pkg::NUM_SLOTS_DEF
) (
   input  wire                  clock,
   input  wire                  reset,
   input  vtp_pkg::req_type     req_item,
   input  vtp_pkg::cmd_type     cmd,
   output vtp_pkg::status_type  status,
   input  wire                  csr_wr,
   input  wire                  csr_index,
   input  wire  [9:0]           csr_wdata,
   output logic                 rsp_valid,
   output vtp_pkg::rsp_type     rsp_item
);

   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   logic [NUM_SLOTS-1:0] active_ff, active_in;
   logic                 periodic_ff [NUM_SLOTS];
   logic [15:0]          period_ff   [NUM_SLOTS];
   logic [16:0]          elapsed_ff  [NUM_SLOTS];

   logic [IDX_W-1:0]     idx_ff, idx_in;
   vtp_pkg::rsp_type     pend_ff, pend_in;
   logic                 pend_valid_ff, pend_valid_in;
   vtp_pkg::rsp_type     rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 base_running_ff, base_running_in;
   logic [9:0]           tick_step_ff, tick_step_in;

   logic                 any_free;
   logic [IDX_W-1:0]     free_idx;
   logic                 start_ok;
   logic                 slot_in_range;
   logic                 stop_ok;
   logic                 scan_last;
   logic                 scan_active;
   logic [16:0]          sum;
   logic                 expire;

   // Lowest free slot: walk from the top so the lowest index wins.
   always_comb begin
      any_free = 1'b0;
      free_idx = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (!active_ff[i]) begin
            any_free = 1'b1;
            free_idx = IDX_W'(i);
         end
      end
   end

   assign start_ok = cmd.start_op && (req_item.period_ms != 16'd0) && base_running_ff
                     && any_free;

   assign slot_in_range = {1'b0, req_item.slot} < (vtp_pkg::SLOT_FIELD_W + 1)'(NUM_SLOTS);
   assign stop_ok = cmd.stop_op && slot_in_range && active_ff[req_item.slot[IDX_W-1:0]];

   assign scan_last   = idx_ff == IDX_W'(NUM_SLOTS - 1);
   assign scan_active = active_ff[idx_ff];
   assign sum         = elapsed_ff[idx_ff] + {7'd0, tick_step_ff};
   assign expire      = cmd.scan_step && scan_active && (sum >= {1'b0, period_ff[idx_ff]});

   always_comb begin
      active_in       = active_ff;
      idx_in          = idx_ff;
      pend_in         = pend_ff;
      pend_valid_in   = pend_valid_ff;
      rsp_in          = rsp_ff;
      rsp_valid_in    = 1'b0;
      base_running_in = base_running_ff;
      tick_step_in    = tick_step_ff;

      if (csr_wr) begin
         case (csr_index)
            vtp_pkg::CSR_BASE_RUNNING: base_running_in = csr_wdata[0];
            vtp_pkg::CSR_TICK_STEP:    tick_step_in    = csr_wdata;
            default: ;
         endcase
      end

      if (cmd.start_op) begin
         rsp_valid_in       = 1'b1;
         rsp_in.kind        = vtp_pkg::KIND_START;
         rsp_in.ok          = start_ok;
         rsp_in.slot_id     = start_ok ? vtp_pkg::SLOT_FIELD_W'(free_idx) : '0;
         rsp_in.period_out  = '0;
         rsp_in.last        = 1'b1;
         if (start_ok) begin
            active_in[free_idx] = 1'b1;
         end
      end

      if (cmd.stop_op) begin
         rsp_valid_in       = 1'b1;
         rsp_in.kind        = vtp_pkg::KIND_STOP;
         rsp_in.ok          = stop_ok;
         rsp_in.slot_id     = req_item.slot;
         rsp_in.period_out  = '0;
         rsp_in.last        = 1'b1;
         if (stop_ok) begin
            active_in[req_item.slot[IDX_W-1:0]] = 1'b0;
         end
      end

      if (cmd.scan_step) begin
         idx_in = scan_last ? '0 : idx_ff + 1'b1;
         if (expire) begin
            // The earlier expiry can go out now: it is known not to be the last.
            if (pend_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_in       = pend_ff;
            end
            pend_valid_in      = 1'b1;
            pend_in.kind       = vtp_pkg::KIND_EXPIRY;
            pend_in.ok         = 1'b1;
            pend_in.slot_id    = vtp_pkg::SLOT_FIELD_W'(idx_ff);
            pend_in.period_out = period_ff[idx_ff];
            pend_in.last       = 1'b0;
            if (!periodic_ff[idx_ff]) begin
               active_in[idx_ff] = 1'b0;
            end
         end
      end

      if (cmd.flush && pend_valid_ff) begin
         rsp_valid_in  = 1'b1;
         rsp_in        = pend_ff;
         rsp_in.last   = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff       <= '0;
         idx_ff          <= '0;
         pend_valid_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         base_running_ff <= vtp_pkg::BASE_RUNNING_RST;
         tick_step_ff    <= vtp_pkg::TICK_STEP_RST;
      end else begin
         active_ff       <= active_in;
         idx_ff          <= idx_in;
         pend_valid_ff   <= pend_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         base_running_ff <= base_running_in;
         tick_step_ff    <= tick_step_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   // Slot store: written by a granted start or by the scan, read at the scan index.
   always_ff @(posedge clock) begin
      if (start_ok) begin
         periodic_ff[free_idx] <= req_item.periodic;
         period_ff[free_idx]   <= req_item.period_ms;
         elapsed_ff[free_idx]  <= '0;
      end else if (cmd.scan_step && scan_active) begin
         elapsed_ff[idx_ff] <= (expire && periodic_ff[idx_ff]) ? 17'd0 : sum;
      end
   end

   assign status.scan_last  = scan_last;
   assign status.pend_valid = pend_valid_ff;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_item          = rsp_ff;

endmodule

`default_nettype wire

// ===== src/vtp_controller.sv =====
// Controller of the virtual timer pool: accepts items and sequences the tick
// scan and the final flush of the pending expiry.
// Depends on vtp_pkg.
`default_nettype none

module vtp_controller (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   input  wire  [1:0]           action,
   input  vtp_pkg::status_type  status,
   output vtp_pkg::cmd_type     cmd,
   output logic                 busy
);

   vtp_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in      = state_ff;
      cmd.start_op  = 1'b0;
      cmd.stop_op   = 1'b0;
      cmd.scan_step = 1'b0;
      cmd.flush     = 1'b0;
      case (state_ff)
         vtp_pkg::ST_IDLE: begin
            if (start) begin
               case (action)
                  vtp_pkg::ACT_START: cmd.start_op = 1'b1;
                  vtp_pkg::ACT_STOP:  cmd.stop_op  = 1'b1;
                  vtp_pkg::ACT_TICK:  state_in     = vtp_pkg::ST_SCAN;
                  default: ;
               endcase
            end
         end
         vtp_pkg::ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = vtp_pkg::ST_FLUSH;
            end
         end
         vtp_pkg::ST_FLUSH: begin
            cmd.flush = 1'b1;
            state_in  = vtp_pkg::ST_IDLE;
         end
         default: begin
            state_in = vtp_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= vtp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = state_ff != vtp_pkg::ST_IDLE;

endmodule

`default_nettype wire

// ===== src/virtual_timer_pool.sv =====
// Top level of the virtual timer pool: controller, datapath and assertions.
// Depends on vtp_pkg, vtp_controller and vtp_datapath.
`default_nettype none

// A pool of NUM_SLOTS timers, each one-shot or periodic. An item is taken when
// start is high and busy is low. A start or stop item's reply appears on the
// cycle after acceptance and busy never rises, so a further item may follow at
// once. A tick item keeps busy high while the scan visits one slot per cycle
// through the single read port of the slot store and while the flush state
// then releases the held expiry. Expiry results come out in slot order, at
// most one per cycle, each in the cycle after the scan step that finds the
// next expiry; the final one, marked last, appears in the same cycle as busy
// falls. A tick with no expiry gives no result. Every result is shown on
// rsp_item for exactly one cycle with rsp_valid high and the receiver cannot
// hold it off. Configuration writes are always taken (csr_ready is tied high)
// and should be made only while the pool is idle.

module virtual_timer_pool #(
   parameter int NUM_SLOTS = vtp_pkg::NUM_SLOTS_DEF
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   output logic               busy,
   input  vtp_pkg::req_type   req_item,
   output logic               rsp_valid,
   output vtp_pkg::rsp_type   rsp_item,
   input  wire                csr_valid,
   output logic               csr_ready,
   input  wire                csr_index,
   input  wire  [9:0]         csr_wdata
);

   vtp_pkg::cmd_type    cmd;
   vtp_pkg::status_type status;

   assign csr_ready = 1'b1;

   vtp_controller u_controller (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .action (req_item.action),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   vtp_datapath #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .cmd       (cmd),
      .status    (status),
      .csr_wr    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   // A start or stop item gets its single reply on the very next cycle.
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_item.action == vtp_pkg::ACT_START ||
                         req_item.action == vtp_pkg::ACT_STOP)
      |=> rsp_valid && rsp_item.last)
   else $error("start or stop reply missing");

   // Replies are always final; only expiries can be followed by more results.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.kind != vtp_pkg::KIND_EXPIRY |-> rsp_item.last)
   else $error("reply not marked last");

   // Expiries come only out of a tick scan and carry a real period.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.kind == vtp_pkg::KIND_EXPIRY
      |-> $past(busy) && rsp_item.ok && rsp_item.period_out != 16'd0)
   else $error("expiry outside a tick scan");

   // No expiry is left held once the pool is back to idle.
   assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> !status.pend_valid)
   else $error("expiry left pending after scan");

endmodule

`default_nettype wire

// ===== sim/vtp_checker.sv =====
// Checker for the virtual timer pool: watches the request, result and register
// channels, predicts every result from its own copy of the slots, and compares.
// Depends on vtp_pkg.
module vtp_checker #(
   parameter int NUM_SLOTS = vtp_pkg::NUM_SLOTS_DEF
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   input  wire                busy,
   input  vtp_pkg::req_type   req_item,
   input  wire                rsp_valid,
   input  vtp_pkg::rsp_type   rsp_item,
   input  wire                csr_valid,
   input  wire                csr_ready,
   input  wire                csr_index,
   input  wire  [9:0]         csr_wdata,
   output int                 fail_count,
   output int                 pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import vtp_pkg::*;

   logic        model_in_use   [NUM_SLOTS];
   logic        timer_periodic [NUM_SLOTS];
   logic [15:0] timer_period   [NUM_SLOTS];
   logic [16:0] timer_elapsed  [NUM_SLOTS];
   logic        run_enabled;
   logic [9:0]  step_ms;
   rsp_type     expected_rsp[$];

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : monitor
      rsp_type want;
      rsp_type held;
      bit      have_held;
      int      free_slot;
      if (reset) begin
         run_enabled = BASE_RUNNING_RST;
         step_ms     = TICK_STEP_RST;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            model_in_use[i]   = 1'b0;
            timer_periodic[i] = 1'b0;
            timer_period[i]   = '0;
            timer_elapsed[i]  = '0;
         end
         expected_rsp.delete();
      end else begin
         // Results are registered, so they always trail their item; the result
         // seen at this edge is compared before the item taken here is predicted.
         if (rsp_valid) begin
            if (expected_rsp.size() == 0) begin
               $error("Unexpected result: kind %0d slot %0d", rsp_item.kind,
                      rsp_item.slot_id);
               fail_count++;
            end else begin
               want = expected_rsp.pop_front();
               check_field("kind", want.kind, rsp_item.kind);
               check_field("ok", want.ok, rsp_item.ok);
               check_field("slot_id", want.slot_id, rsp_item.slot_id);
               check_field("period_out", want.period_out, rsp_item.period_out);
               check_field("last", want.last, rsp_item.last);
            end
         end

         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BASE_RUNNING: run_enabled = csr_wdata[0];
               CSR_TICK_STEP:    step_ms = csr_wdata;
               default: ;
            endcase
         end

         if (start && !busy) begin
            case (req_item.action)
               ACT_START: begin
                  free_slot = -1;
                  if (req_item.period_ms != 0 && run_enabled) begin
                     for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
                        if (!model_in_use[i]) free_slot = i;
                     end
                  end
                  if (free_slot < 0) begin
                     expected_rsp.push_back('{kind: KIND_START, ok: 1'b0, slot_id: 4'd0,
                                              period_out: 16'd0, last: 1'b1});
                  end else begin
                     model_in_use[free_slot]   = 1'b1;
                     timer_periodic[free_slot] = req_item.periodic;
                     timer_period[free_slot]   = req_item.period_ms;
                     timer_elapsed[free_slot]  = '0;
                     expected_rsp.push_back('{kind: KIND_START, ok: 1'b1,
                                              slot_id: 4'(free_slot),
                                              period_out: 16'd0, last: 1'b1});
                  end
               end
               ACT_STOP: begin
                  want = '{kind: KIND_STOP, ok: 1'b0, slot_id: req_item.slot,
                           period_out: 16'd0, last: 1'b1};
                  if (int'(req_item.slot) < NUM_SLOTS) begin
                     if (model_in_use[req_item.slot]) begin
                        model_in_use[req_item.slot] = 1'b0;
                        want.ok = 1'b1;
                     end
                  end
                  expected_rsp.push_back(want);
               end
               ACT_TICK: begin
                  // Each expiry is held back one slot so the final one can be marked.
                  have_held = 1'b0;
                  for (int i = 0; i < NUM_SLOTS; i++) begin
                     if (model_in_use[i]) begin
                        timer_elapsed[i] = timer_elapsed[i] + 17'(step_ms);
                        if (timer_elapsed[i] >= 17'(timer_period[i])) begin
                           if (timer_periodic[i]) timer_elapsed[i] = '0;
                           else model_in_use[i] = 1'b0;
                           if (have_held) expected_rsp.push_back(held);
                           held = '{kind: KIND_EXPIRY, ok: 1'b1, slot_id: 4'(i),
                                    period_out: timer_period[i], last: 1'b0};
                           have_held = 1'b1;
                        end
                     end
                  end
                  if (have_held) begin
                     held.last = 1'b1;
                     expected_rsp.push_back(held);
                  end
               end
               default: ;
            endcase
         end
      end
      pending <= expected_rsp.size();
   end

endmodule

// ===== sim/tb.sv =====
// Testbench top for the virtual timer pool: clock, reset, stimulus and verdict.
// Depends on vtp_pkg, virtual_timer_pool and vtp_checker.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import vtp_pkg::*;

   localparam int NUM_SLOTS = NUM_SLOTS_DEF;
   // The fourth action encoding has no meaning and must be ignored by the pool.
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   req_type    req_item;
   logic       rsp_valid;
   rsp_type    rsp_item;
   logic       csr_valid;
   logic       csr_ready;
   logic       csr_index;
   logic [9:0] csr_wdata;
   int         fail_count;
   int         pending;
   bit         stuck;
   logic [9:0] step_now;

   virtual_timer_pool #(
      .NUM_SLOTS(NUM_SLOTS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   vtp_checker #(
      .NUM_SLOTS(NUM_SLOTS)
   ) timer_checker (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_valid  (rsp_valid),
      .rsp_item   (rsp_item),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog. The timeout lies far beyond the slowest legal run, so it can
   // only be reached if the pool has hung.
   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

   function automatic req_type timer_req(input logic [1:0] action,
                                         input logic [15:0] period,
                                         input logic periodic,
                                         input logic [3:0] slot);
      req_type it;
      it.action    = action;
      it.period_ms = period;
      it.periodic  = periodic;
      it.slot      = slot;
      return it;
   endfunction

   // Random item for the current tick step. Most start periods are a few ticks
   // long so that timers really expire; now and then the period is zero or
   // drawn from the whole field. Stops mostly aim at real slots, but a quarter
   // of them may name any index the field can carry.
   function automatic req_type random_item(input logic [9:0] step);
      req_type it;
      int      pick;
      int      span;
      it = timer_req(ACT_TICK, 16'($urandom), 1'($urandom), 4'($urandom));
      span = (step == 0) ? 60 : int'(step) * 6;
      if (span > 65535) span = 65535;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         it.action = ACT_TICK;
      end else if (pick < 70) begin
         it.action = ACT_START;
         case ($urandom_range(0, 9))
            0: ;
            1: it.period_ms = '0;
            default: it.period_ms = 16'($urandom_range(1, span));
         endcase
      end else if (pick < 95) begin
         it.action = ACT_STOP;
         if ($urandom_range(0, 3) != 0) it.slot = 4'($urandom_range(0, NUM_SLOTS - 1));
      end else begin
         it.action = ACT_UNUSED;
      end
      return it;
   endfunction

   // Presents one item at the falling edge and holds it until the pool takes
   // it. Start is left high afterwards; the next call or drain lowers or
   // reuses it at the following falling edge, so it is never toggled twice in
   // one step.
   task automatic send_item(input req_type it, input bit may_idle);
      int gap;
      if (may_idle && $urandom_range(0, 99) < 10) begin
         gap = $urandom_range(1, 4);
         repeat (gap) begin
            @(negedge clock);
            start <= 1'b0;
         end
      end
      @(negedge clock);
      start    <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (busy);
   endtask

   // Stops sending and waits for every outstanding result. A tick that expires
   // nothing leaves no trace in the checker, so the task also waits for busy to
   // fall and then idles on before anything else, such as a register write.
   task automatic drain_results();
      int waited;
      waited = 0;
      @(negedge clock);
      start <= 1'b0;
      while ((pending != 0 || busy) && waited < 1000) begin
         @(negedge clock);
         waited++;
      end
      if (pending != 0) begin
         $error("%0d expected results never arrived", pending);
         stuck = 1'b1;
      end
      repeat (12) @(negedge clock);
   endtask

   task automatic write_reg(input logic index, input logic [9:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      reset     = 1'b1;
      start     = 1'b0;
      req_item  = '0;
      csr_valid = 1'b0;
      csr_index = 1'b0;
      csr_wdata = '0;
      stuck     = 1'b0;
      step_now  = TICK_STEP_RST;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, run with the reset settings (base tick on, step of 10).
      // A tick over an empty pool gives nothing, a zero period is refused, and
      // stops on an index beyond the pool or on an idle slot fail and echo it.
      send_item(timer_req(ACT_TICK, 16'd0, 1'b0, 4'd0), 1'b0);
      send_item(timer_req(ACT_START, 16'd0, 1'b1, 4'd0), 1'b0);
      send_item(timer_req(ACT_STOP, 16'hFFFF, 1'b1, 4'd15), 1'b0);
      send_item(timer_req(ACT_STOP, 16'd0, 1'b0, 4'd0), 1'b0);
      // Fill all six slots with a mix of modes and periods, from the smallest
      // to the largest, then one more start which must find the pool full.
      send_item(timer_req(ACT_START, 16'd10, 1'b1, 4'd0), 1'b0);
      send_item(timer_req(ACT_START, 16'hFFFF, 1'b0, 4'd0), 1'b0);
      send_item(timer_req(ACT_START, 16'd5, 1'b0, 4'd0), 1'b0);
      send_item(timer_req(ACT_START, 16'd20, 1'b1, 4'd0), 1'b0);
      send_item(timer_req(ACT_START, 16'd30, 1'b0, 4'd0), 1'b0);
      send_item(timer_req(ACT_START, 16'd1, 1'b0, 4'd0), 1'b0);
      send_item(timer_req(ACT_START, 16'd7, 1'b0, 4'd0), 1'b0);
      // Three expiries on the first tick, periodic and one-shot alike, then
      // the periodic slots coming round again.
      send_item(timer_req(ACT_TICK, 16'd0, 1'b0, 4'd0), 1'b0);
      send_item(timer_req(ACT_TICK, 16'd0, 1'b0, 4'd0), 1'b0);
      send_item(timer_req(ACT_STOP, 16'd0, 1'b0, 4'd1), 1'b0);
      send_item(timer_req(ACT_STOP, 16'd0, 1'b0, 4'd1), 1'b0);
      send_item(timer_req(ACT_STOP, 16'd0, 1'b0, 4'(NUM_SLOTS)), 1'b0);
      send_item(timer_req(ACT_UNUSED, 16'hFFFF, 1'b1, 4'd15), 1'b0);
      send_item(timer_req(ACT_TICK, 16'd0, 1'b0, 4'd0), 1'b0);
      // Let the pool empty its output completely before touching a register.
      drain_results();
      write_reg(CSR_BASE_RUNNING, 10'd0);
      send_item(timer_req(ACT_START, 16'd100, 1'b1, 4'd0), 1'b0);
      drain_results();
      write_reg(CSR_BASE_RUNNING, 10'd1);
      send_item(timer_req(ACT_STOP, 16'd0, 1'b0, 4'd0), 1'b0);
      send_item(timer_req(ACT_STOP, 16'd0, 1'b0, 4'd3), 1'b0);
      send_item(timer_req(ACT_START, 16'd15, 1'b1, 4'd0), 1'b0);

      // Random part in six settings: the reset step, the smallest and largest
      // steps, a zero step under which nothing can expire, the base tick off
      // so that every start is refused, and finally a random step. The second
      // setting inserts no random idle cycles between items.
      for (int phase = 0; phase < 6; phase++) begin
         drain_results();
         case (phase)
            0: step_now = 10'd10;
            1: step_now = 10'd1;
            2: step_now = 10'h3FF;
            3: step_now = 10'd0;
            4: step_now = 10'd3;
            default: step_now = 10'($urandom_range(1, 1000));
         endcase
         write_reg(CSR_TICK_STEP, step_now);
         write_reg(CSR_BASE_RUNNING, (phase == 4) ? 10'd0 : 10'd1);
         for (int k = 0; k < 52; k++) begin
            send_item(random_item(step_now), phase != 1);
            // Occasionally hold off until the pool has caught up completely.
            if ($urandom_range(0, 39) == 0) drain_results();
         end
      end

      drain_results();
      repeat (20) @(negedge clock);
      if (fail_count == 0 && !stuck) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/vtp_pkg.sv
src/vtp_datapath.sv
src/vtp_controller.sv
src/virtual_timer_pool.sv
sim/vtp_checker.sv
sim/tb.sv
